/* src/lcbg_pkg.sv */
// ----------------------------------------------------------------------------
// lcbg_pkg: shared types, constants and sine table for the chirp burst generator
// Holds the serial datapath digit sizes, the register index codes, the
// sequencer states and the quarter-wave sine ROM built at elaboration.
// ----------------------------------------------------------------------------
package lcbg_pkg;

  // Burst length limit and sine table size
  localparam int unsigned MAX_LENGTH      = 65535;
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned QUARTER_BITS    = SINE_TABLE_BITS - 2;
  localparam int unsigned QUARTER_SIZE    = 1 << QUARTER_BITS;
  localparam int unsigned POS_W           = QUARTER_BITS + 1;

  // Field widths
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned INC_W    = 48;
  localparam int unsigned ENV_W    = 25;
  localparam int unsigned VOL_W    = 16;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned SINE_W   = 15;
  localparam int unsigned SAMPLE_W = 16;

  localparam int unsigned ENV_ONE  = 1 << 24;
  localparam int unsigned SINE_MAX = 32767;
  localparam int unsigned OUT_SHIFT = 39;

  // Serial digit sizes: increment and phase in 16-bit digits, envelope in 5-bit digits
  localparam int unsigned INC_DIG_W  = 16;
  localparam int unsigned INC_DIGITS = INC_W / INC_DIG_W;
  localparam int unsigned PH_DIGITS  = PHASE_W / INC_DIG_W;
  localparam int unsigned PH_FIRST   = INC_DIGITS - PH_DIGITS;
  localparam int unsigned ENV_DIG_W  = 5;
  localparam int unsigned ENV_DIGITS = ENV_W / ENV_DIG_W;
  localparam int unsigned STEP_W     = 3;

  // envelope x volume product, kept whole
  localparam int unsigned VE_HI_W = VOL_W + 1;
  localparam int unsigned VE_W    = VE_HI_W + ENV_W;
  localparam int unsigned PROD_W  = VE_W + SINE_W;
  localparam int unsigned TOP_W   = PROD_W - OUT_SHIFT;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_INCREMENT = 3'd0,
    CFG_INCREMENT_SLOPE = 3'd1,
    CFG_SAMPLE_COUNT    = 3'd2,
    CFG_ENVELOPE_STEP   = 3'd3,
    CFG_VOLUME          = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_PROD,
    ST_OUT
  } state_t;

  // Taylor series divisors (2n)(2n+1) for n = 1..10
  localparam int unsigned TAYLOR_TERMS = 10;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
    '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};
  localparam longint unsigned HALF_PI_Q30 = 1686629713;

  typedef logic [SINE_W-1:0] sine_rom_t [QUARTER_SIZE+1];

  // One quarter-wave entry: round(32767 * sin(k/Q * pi/2)), sine by Q30 series
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    int unsigned        n;
    x    = (64'(k) * HALF_PI_Q30) >> QUARTER_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (n = 1; n <= TAYLOR_TERMS; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if (n[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    v = (64'(sum) * 64'(SINE_MAX) + (64'd1 << 29)) >> 30;
    if (v > 64'(SINE_MAX)) begin
      v = 64'(SINE_MAX);
    end
    return v[SINE_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    int unsigned k;
    for (k = 0; k <= QUARTER_SIZE; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* src/linear_chirp_burst_generator_top.sv */
// ----------------------------------------------------------------------------
// linear_chirp_burst_generator_top: DDS linear chirp burst, serial datapath
// Each accepted item (in_restart) yields one audio sample item:
// sine(phase) x volume x envelope with a linear frequency sweep.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_stall carries in_restart. A high restart starts
//    a new burst (phase, index cleared, envelope full, increment loaded) before
//    that item's sample. Outside a burst each item returns a zero sample with
//    out_done_res set.
//  - Output channel out_valid/out_stall carries out_sample, out_last_sample
//    and out_done_res. out_last_sample marks the final sample of a burst.
//  - Config channel cfg_valid/cfg_ready, cfg_index/cfg_data; cfg_ready is
//    always high. Write only while no item is in flight. Unknown index ignored.
//  - Steps per item: accept, five serial digit steps, one product step and
//    one output step; the input stalls until the item is through. The five
//    steps are set by the envelope, which runs 25 bits in 5-bit digits;
//    increment and phase adds run alongside in 16-bit digits. An idle item
//    goes from accept straight to the output step.
//  - The output register decouples the sides: the next item is accepted while
//    a result waits; if the receiver still stalls when the next result is
//    ready, the block holds it and stalls its input.
//  - Reset (rst_n low, synchronous): burst idle, config at defaults.
// ----------------------------------------------------------------------------
module linear_chirp_burst_generator_top
  import lcbg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // input item channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_restart,
  // result item channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_last_sample,
  output logic                       out_done_res,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  // config registers
  logic [INC_W-2:0]   cfg_start_increment_r;
  logic [INC_W-1:0]   cfg_increment_slope_r;
  logic [CNT_W-1:0]   cfg_sample_count_r;
  logic [ENV_W-1:0]   cfg_envelope_step_r;
  logic [VOL_W-1:0]   cfg_volume_r;

  // burst state; phase, increment and envelope rotate digit by digit
  logic [PHASE_W-1:0] phase_r;
  logic [INC_W-1:0]   inc_r;
  logic [ENV_W-1:0]   env_r;
  logic [CNT_W-1:0]   idx_r;
  logic               running_r;

  // sequencer
  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r;
  logic               idle_tick_r;

  // serial carries and partial products
  logic               inc_carry_r;
  logic               ph_carry_r;
  logic               env_borrow_r;
  logic [VE_HI_W-1:0] ve_hi_r;
  logic [ENV_W-1:0]   ve_lo_r;
  logic [SINE_W-1:0]  mag_r;
  logic               neg_r;
  logic [TOP_W-1:0]   prod_r;
  logic               last_r;

  // output register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_last_r;
  logic                       out_done_r;

  logic accept;
  logic out_load;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_last_sample = out_last_r;
  assign out_done_res    = out_done_r;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // idle item skips the datapath
          state_nxt = (in_restart || running_r) ? ST_RUN : ST_OUT;
        end
      end
      ST_RUN: begin
        if (step_r == STEP_W'(ENV_DIGITS - 1)) begin
          state_nxt = ST_PROD;
        end
      end
      ST_PROD: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------ serial digits
  logic [INC_W-1:0]       slope_sh;
  logic [INC_DIG_W-1:0]   slope_dig;
  logic [INC_DIG_W:0]     inc_sum;
  logic [INC_DIG_W:0]     ph_sum;
  logic [ENV_W-1:0]       step_sh;
  logic [ENV_DIG_W:0]     env_diff;
  logic [ENV_DIG_W-1:0]   env_dig;
  logic [VE_HI_W+ENV_DIG_W-1:0] ve_sum;
  logic                   inc_active;
  logic                   ph_active;

  assign inc_active = (step_r < STEP_W'(INC_DIGITS));
  assign ph_active  = (step_r >= STEP_W'(PH_FIRST)) && inc_active;

  always_comb begin
    slope_sh  = cfg_increment_slope_r >> (INC_DIG_W * step_r);
    slope_dig = slope_sh[INC_DIG_W-1:0];
    // increment digit: old digit sits at the bottom, new one enters at the top
    inc_sum   = {1'b0, inc_r[INC_DIG_W-1:0]} + {1'b0, slope_dig}
              + (INC_DIG_W+1)'((step_r == '0) ? 1'b0 : inc_carry_r);
    // phase uses the old increment digits above bit 16
    ph_sum    = {1'b0, phase_r[INC_DIG_W-1:0]} + {1'b0, inc_r[INC_DIG_W-1:0]}
              + (INC_DIG_W+1)'((step_r == STEP_W'(PH_FIRST)) ? 1'b0 : ph_carry_r);
    step_sh   = cfg_envelope_step_r >> (ENV_DIG_W * step_r);
    env_dig   = env_r[ENV_DIG_W-1:0];
    env_diff  = {1'b0, env_dig} - {1'b0, step_sh[ENV_DIG_W-1:0]}
              - (ENV_DIG_W+1)'((step_r == '0) ? 1'b0 : env_borrow_r);
    // volume x envelope, one envelope digit per step
    ve_sum    = (VE_HI_W+ENV_DIG_W)'((step_r == '0) ? '0 : ve_hi_r)
              + (VE_HI_W+ENV_DIG_W)'(cfg_volume_r) * (VE_HI_W+ENV_DIG_W)'(env_dig);
  end

  // ROM address from the top phase bits, mirrored in odd quadrants
  logic [SINE_TABLE_BITS-1:0] rom_idx;
  logic [POS_W-1:0]           rom_pos;

  always_comb begin
    rom_idx = phase_r[PHASE_W-1 -: SINE_TABLE_BITS];
    if (rom_idx[QUARTER_BITS]) begin
      rom_pos = POS_W'(QUARTER_SIZE) - {1'b0, rom_idx[QUARTER_BITS-1:0]};
    end else begin
      rom_pos = {1'b0, rom_idx[QUARTER_BITS-1:0]};
    end
  end

  // final product and burst-length check
  logic [PROD_W-1:0] prod_full;
  logic [CNT_W:0]    limit;
  logic [CNT_W:0]    idx_inc;

  always_comb begin
    prod_full = PROD_W'(mag_r) * PROD_W'({ve_hi_r, ve_lo_r});
    limit     = {1'b0, cfg_sample_count_r};
    if (32'(cfg_sample_count_r) > MAX_LENGTH) begin
      limit = (CNT_W+1)'(MAX_LENGTH);
    end
    if (limit == '0) begin
      limit = (CNT_W+1)'(1);
    end
    idx_inc = {1'b0, idx_r} + (CNT_W+1)'(1);
  end

  // saturate and reapply sign
  logic [SINE_W-1:0]   sat_mag;
  logic [SAMPLE_W-1:0] smp;

  always_comb begin
    sat_mag = (prod_r > TOP_W'(SINE_MAX)) ? SINE_W'(SINE_MAX) : prod_r[SINE_W-1:0];
    smp     = neg_r ? (SAMPLE_W'(0) - {1'b0, sat_mag}) : {1'b0, sat_mag};
  end

  // ------------------------------------------------------------------ datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_start_increment_r <= (INC_W-1)'(47'd2553061013248);
      cfg_increment_slope_r <= INC_W'(48'd385950267);
      cfg_sample_count_r    <= CNT_W'(6615);
      cfg_envelope_step_r   <= ENV_W'(2536);
      cfg_volume_r          <= VOL_W'(13107);
      phase_r               <= '0;
      inc_r                 <= '0;
      env_r                 <= '0;
      idx_r                 <= '0;
      running_r             <= 1'b0;
      step_r                <= '0;
      idle_tick_r           <= 1'b0;
      out_valid_r           <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_INCREMENT: cfg_start_increment_r <= cfg_data[INC_W-2:0];
          CFG_INCREMENT_SLOPE: cfg_increment_slope_r <= cfg_data[INC_W-1:0];
          CFG_SAMPLE_COUNT:    cfg_sample_count_r    <= cfg_data[CNT_W-1:0];
          CFG_ENVELOPE_STEP:   cfg_envelope_step_r   <= cfg_data[ENV_W-1:0];
          CFG_VOLUME:          cfg_volume_r          <= cfg_data[VOL_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          step_r <= '0;
          if (accept) begin
            idle_tick_r <= !(in_restart || running_r);
            if (in_restart) begin
              phase_r   <= '0;
              idx_r     <= '0;
              env_r     <= ENV_W'(ENV_ONE);
              inc_r     <= {1'b0, cfg_start_increment_r};
              running_r <= 1'b1;
            end
          end
        end
        ST_RUN: begin
          step_r       <= step_r + STEP_W'(1);
          env_r        <= {env_diff[ENV_DIG_W-1:0], env_r[ENV_W-1:ENV_DIG_W]};
          env_borrow_r <= env_diff[ENV_DIG_W];
          ve_hi_r      <= ve_sum[VE_HI_W+ENV_DIG_W-1:ENV_DIG_W];
          ve_lo_r      <= {ve_sum[ENV_DIG_W-1:0], ve_lo_r[ENV_W-1:ENV_DIG_W]};
          if (inc_active) begin
            inc_r       <= {inc_sum[INC_DIG_W-1:0], inc_r[INC_W-1:INC_DIG_W]};
            inc_carry_r <= inc_sum[INC_DIG_W];
          end
          if (ph_active) begin
            phase_r    <= {ph_sum[INC_DIG_W-1:0], phase_r[PHASE_W-1:INC_DIG_W]};
            ph_carry_r <= ph_sum[INC_DIG_W];
          end
          // phase is complete once the increment digits are done
          if (step_r == STEP_W'(INC_DIGITS)) begin
            mag_r <= SINE_ROM[rom_pos];
            neg_r <= rom_idx[QUARTER_BITS+1];
          end
        end
        ST_PROD: begin
          prod_r <= prod_full[PROD_W-1:OUT_SHIFT];
          // envelope saturates at zero
          if (env_borrow_r) begin
            env_r <= '0;
          end
          last_r <= (idx_inc >= limit);
          idx_r  <= idx_inc[CNT_W-1:0];
          if (idx_inc >= limit) begin
            running_r <= 1'b0;
          end
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (idle_tick_r) begin
        out_sample_r <= '0;
        out_last_r   <= 1'b0;
        out_done_r   <= 1'b1;
      end else begin
        out_sample_r <= signed'(smp);
        out_last_r   <= last_r;
        out_done_r   <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- assertions
  // a new result only ever comes from the output step
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result appeared outside output step");

  // an accepted item keeps the input stalled on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input not stalled after accept");

  // envelope never above unity between items
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (env_r <= ENV_W'(ENV_ONE)))
    else $error("envelope above unity");

  // a burst ends only on its last sample
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(running_r) |-> last_r)
    else $error("burst ended without last sample");

  // idle results are zero and never marked last
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (out_sample_r == '0 && !out_last_r))
    else $error("idle result not zero");

endmodule

/* sim/tb_linear_chirp_burst_generator_top.sv */
// ----------------------------------------------------------------------------
// tb_linear_chirp_burst_generator_top: self-checking bench for the chirp burst
// A directed table covers reset idle, quadrant peaks, gain saturation, restart
// mid burst, zero count, increment wrap and ignored register codes. Random
// phases follow with new register settings, bursts of ticks with stray
// restarts, sender gaps and receiver stalls. Each sample item is checked against
// its hand-typed result or an in-bench DDS model.
// ----------------------------------------------------------------------------
module tb_linear_chirp_burst_generator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lcbg_pkg::*;

  localparam int unsigned LATENCY     = 7;       // accept to result of a burst item
  localparam int unsigned CYCLE_LIMIT = 500000;  // cycle cap that ends a hung run
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 100;

  localparam logic [ENV_W-1:0] ENV_FULL    = 25'd16777216;
  localparam logic [63:0]      QUARTER_Q30 = 64'd1686629713;  // pi/2 in Q30
  localparam logic [63:0]      TONE_PEAK   = 64'd32767;

  // register values right after reset
  localparam logic [INC_W-2:0] DEF_START_INC = 47'd2553061013248;
  localparam logic [INC_W-1:0] DEF_SLOPE     = 48'd385950267;
  localparam logic [CNT_W-1:0] DEF_COUNT     = 16'd6615;
  localparam logic [ENV_W-1:0] DEF_ENV_STEP  = 25'd2536;
  localparam logic [VOL_W-1:0] DEF_VOLUME    = 16'd13107;

  // register codes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       last;
    logic                       done;
  } chirp_out_t;

  localparam chirp_out_t IDLE_OUT  = '{smp: 16'sd0, last: 1'b0, done: 1'b1};
  localparam chirp_out_t ZERO_RUN  = '{smp: 16'sd0, last: 1'b0, done: 1'b0};
  localparam chirp_out_t ZERO_LAST = '{smp: 16'sd0, last: 1'b1, done: 1'b0};
  localparam chirp_out_t PEAK_POS  = '{smp: 16'sd32767, last: 1'b0, done: 1'b0};
  localparam chirp_out_t PEAK_NEG  = '{smp: -16'sd32767, last: 1'b0, done: 1'b0};
  localparam chirp_out_t PEAK_LAST = '{smp: 16'sd32767, last: 1'b1, done: 1'b0};

  typedef enum bit {ROW_CFG, ROW_TICK} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic                 restart;
    logic                 typed;   // 1: want holds the result, else the model decides
    chirp_out_t           want;
  } plan_row_t;

  localparam int unsigned PLAN_ROWS = 38;

  // Directed plan. Start increment 2^46 puts successive ticks on the quadrant
  // points (peak, zero, trough, zero), which makes those samples obvious.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // idle straight out of reset
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b0, 1'b1, IDLE_OUT},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b0, 1'b1, IDLE_OUT},
    // unity gain, flat sweep, flat envelope, quarter-turn steps, 4 samples
    '{ROW_CFG, CFG_VOLUME, 48'd32768, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_CFG, CFG_INCREMENT_SLOPE, 48'd0, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_CFG, CFG_ENVELOPE_STEP, 48'd0, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_CFG, CFG_START_INCREMENT, 48'h4000_0000_0000, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_CFG, CFG_SAMPLE_COUNT, 48'd4, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b1, 1'b1, PEAK_POS},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b0, 1'b1, ZERO_RUN},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b0, 1'b1, PEAK_NEG},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b0, 1'b1, ZERO_LAST},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b0, 1'b1, IDLE_OUT},
    // gain above unity saturates, then restart inside a running burst
    '{ROW_CFG, CFG_VOLUME, 48'hFFFF, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b1, 1'b1, PEAK_POS},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b1, 1'b1, PEAK_POS},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b0, 1'b0, ZERO_RUN},
    // zero count acts as a one-sample burst
    '{ROW_CFG, CFG_SAMPLE_COUNT, 48'd0, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b1, 1'b1, PEAK_LAST},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b0, 1'b1, IDLE_OUT},
    // register maxima; most negative slope wraps the increment backward
    '{ROW_CFG, CFG_START_INCREMENT, 48'h7FFF_FFFF_FFFF, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_CFG, CFG_INCREMENT_SLOPE, 48'h8000_0000_0000, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_CFG, CFG_ENVELOPE_STEP, 48'h1FF_FFFF, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_CFG, CFG_SAMPLE_COUNT, 48'hFFFF, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b1, 1'b0, ZERO_RUN},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b0, 1'b1, ZERO_RUN},
    // undecoded codes must leave every register alone
    '{ROW_CFG, CFG_ENVELOPE_STEP, 48'h1000, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_CFG, CFG_SPARE_FIRST, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_CFG, CFG_SPARE_LAST, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b1, 1'b0, ZERO_RUN},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b0, 1'b0, ZERO_RUN},
    // new slope and gain while the burst keeps running
    '{ROW_CFG, CFG_INCREMENT_SLOPE, 48'h7FFF_FFFF_FFFF, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_CFG, CFG_VOLUME, 48'd12000, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b0, 1'b0, ZERO_RUN},
    // zero start increment gives a zero first phase; full step empties the envelope
    '{ROW_CFG, CFG_START_INCREMENT, 48'd0, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_CFG, CFG_ENVELOPE_STEP, 48'h100_0000, 1'b0, 1'b0, ZERO_RUN},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b1, 1'b1, ZERO_RUN},
    '{ROW_TICK, CFG_START_INCREMENT, 48'd0, 1'b0, 1'b1, ZERO_RUN}
  };

  // DUT ports
  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_restart;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [SAMPLE_W-1:0]   out_sample;
  logic                         out_last_sample;
  logic                         out_done_res;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;

  // travels with each item: a hand-typed result, if the plan row has one
  logic       tag_typed;
  chirp_out_t tag_want;

  // model copy of the registers
  logic [INC_W-2:0] r_start_inc;
  logic [INC_W-1:0] r_slope;
  logic [CNT_W-1:0] r_count;
  logic [ENV_W-1:0] r_env_step;
  logic [VOL_W-1:0] r_volume;

  // model copy of the burst state
  logic [PHASE_W-1:0] acc_phase;
  logic [INC_W-1:0]   acc_incr;
  logic [ENV_W-1:0]   env_lvl;
  logic [CNT_W-1:0]   smp_idx;
  logic               burst_on;

  logic [SINE_W-1:0] tone_rom [QUARTER_SIZE+1];

  chirp_out_t expected_samples [$];
  int unsigned errors;
  int unsigned cycle_count;

  // driver bookkeeping
  bit in_busy;
  bit cfg_busy;
  int burst_left;

  linear_chirp_burst_generator_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample      (out_sample),
    .out_last_sample (out_last_sample),
    .out_done_res    (out_done_res),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Quarter-wave level: sin by an eleven-term Q30 Taylor series, scaled to 32767
  // with rounding. Angle is truncated to Q30.
  function automatic logic [SINE_W-1:0] quarter_level(input int unsigned k);
    logic [63:0]        ang;
    logic [63:0]        ang_sq;
    logic [63:0]        trm;
    logic [63:0]        scaled;
    logic signed [63:0] acc;
    int unsigned        n;
    ang    = (64'(k) * QUARTER_Q30) >> QUARTER_BITS;
    ang_sq = (ang * ang) >> 30;
    trm    = ang;
    acc    = $signed(ang);
    for (n = 1; n <= 10; n++) begin
      trm = ((trm * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - $signed(trm);
      end else begin
        acc = acc + $signed(trm);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    scaled = ($unsigned(acc) * TONE_PEAK + (64'd1 << 29)) >> 30;
    if (scaled > TONE_PEAK) begin
      scaled = TONE_PEAK;
    end
    return scaled[SINE_W-1:0];
  endfunction

  initial begin : fill_tone_rom
    int unsigned k;
    for (k = 0; k <= QUARTER_SIZE; k++) begin
      tone_rom[k] = quarter_level(k);
    end
  end

  // One sample tick of the chirp: restart, phase step, sine lookup with
  // quadrant folding, gain, then sweep, envelope and index updates.
  task automatic advance_chirp(input logic rs, output chirp_out_t res);
    logic [SINE_TABLE_BITS-1:0] addr;
    logic [POS_W-1:0]           pos;
    logic [63:0]                mix;
    logic [SAMPLE_W-1:0]        mag;
    int unsigned                span;
    if (rs) begin
      acc_phase = '0;
      smp_idx   = '0;
      env_lvl   = ENV_FULL;
      acc_incr  = {1'b0, r_start_inc};
      burst_on  = 1'b1;
    end
    res = IDLE_OUT;
    if (burst_on) begin
      span = (r_count == 0) ? 1 : r_count;
      if (span > MAX_LENGTH) begin
        span = MAX_LENGTH;
      end
      acc_phase = acc_phase + acc_incr[INC_W-1 -: PHASE_W];
      addr      = acc_phase[PHASE_W-1 -: SINE_TABLE_BITS];
      pos       = {1'b0, addr[QUARTER_BITS-1:0]};
      if (addr[QUARTER_BITS]) begin
        pos = POS_W'(QUARTER_SIZE) - pos;  // mirrored quadrant
      end
      mix = (64'(tone_rom[pos]) * 64'(r_volume) * 64'(env_lvl)) >> OUT_SHIFT;
      if (mix > TONE_PEAK) begin
        mix = TONE_PEAK;
      end
      mag      = mix[SAMPLE_W-1:0];
      res.smp  = addr[SINE_TABLE_BITS-1] ? -mag : mag;
      res.last = (smp_idx + 1) >= span;
      res.done = 1'b0;
      acc_incr = acc_incr + r_slope;
      env_lvl  = (env_lvl > r_env_step) ? env_lvl - r_env_step : '0;
      smp_idx  = smp_idx + 1'b1;
      if (res.last) begin
        burst_on = 1'b0;
      end
    end
  endtask

  // Scoreboard. All handshakes are sampled at the rising edge, so the values
  // read here are the ones the DUT saw.
  always @(posedge clk) begin : scoreboard
    chirp_out_t got;
    chirp_out_t want;
    chirp_out_t calc;
    if (!rst_n) begin
      r_start_inc = DEF_START_INC;
      r_slope     = DEF_SLOPE;
      r_count     = DEF_COUNT;
      r_env_step  = DEF_ENV_STEP;
      r_volume    = DEF_VOLUME;
      acc_phase   = '0;
      acc_incr    = '0;
      env_lvl     = '0;
      smp_idx     = '0;
      burst_on    = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_INCREMENT: r_start_inc = cfg_data[INC_W-2:0];
          CFG_INCREMENT_SLOPE: r_slope     = cfg_data[INC_W-1:0];
          CFG_SAMPLE_COUNT:    r_count     = cfg_data[CNT_W-1:0];
          CFG_ENVELOPE_STEP:   r_env_step  = cfg_data[ENV_W-1:0];
          CFG_VOLUME:          r_volume    = cfg_data[VOL_W-1:0];
          default: ;  // undecoded code, ignored
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{smp: out_sample, last: out_last_sample, done: out_done_res};
        if (expected_samples.size() == 0) begin
          $error("unexpected sample item: sample %0d last %0b done %0b",
                 got.smp, got.last, got.done);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (got.smp !== want.smp) begin
            $error("sample: expected %0d, got %0d", want.smp, got.smp);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last_sample: expected %0b, got %0b", want.last, got.last);
            errors++;
          end
          if (got.done !== want.done) begin
            $error("done_res: expected %0b, got %0b", want.done, got.done);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        // model always steps so its state stays in line with typed rows
        advance_chirp(in_restart, calc);
        expected_samples.push_back(tag_typed ? tag_want : calc);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_linear_chirp_burst_generator_top: FAIL");
      $finish;
    end
  end

  // Receiver: stretches of no stall, random stall, heavy stall and solid
  // stall, each of random length.
  initial begin : receiver
    int mode;
    int stretch;
    out_stall <= 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = (mode == 3) ? $urandom_range(2, 24) : $urandom_range(4, 60);
      repeat (stretch) begin
        @(posedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 1) == 1);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= 1'b1;
        endcase
      end
    end
  end

  // Sends one tick item. Items go out in bursts; a gap of random length may
  // follow each burst.
  task automatic send_tick(input logic rs, input logic typed, input chirp_out_t want);
    int gap;
    if (cfg_busy) begin
      cfg_valid <= 1'b0;
      cfg_busy = 1'b0;
    end
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    in_valid   <= 1'b1;
    in_restart <= rs;
    tag_typed  <= typed;
    tag_want   <= want;
    in_busy = 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 :
            ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 9);
      if (gap != 0) begin
        in_valid <= 1'b0;
        in_busy = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop sending and let every outstanding sample come back.
  task automatic wait_quiet();
    if (in_busy) begin
      in_valid <= 1'b0;
      in_busy = 1'b0;
    end
    burst_left = 0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (LATENCY + 1) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_busy = 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  initial begin : stimulus
    int unsigned           i;
    int unsigned           ph;
    int unsigned           k;
    int unsigned           span;
    int                    left;
    logic                  rs;
    logic [CNT_W-1:0]      cnt;
    logic [CFG_DATA_W-1:0] val;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_restart <= 1'b0;
    tag_typed  <= 1'b0;
    tag_want   <= ZERO_RUN;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_START_INCREMENT;
    cfg_data   <= '0;
    in_busy    = 1'b0;
    cfg_busy   = 1'b0;
    burst_left = 0;
    errors     = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; registers change only with nothing in flight
    for (i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        if (i > 0 && PLAN[i-1].kind == ROW_TICK) begin
          wait_quiet();
        end
        write_reg(PLAN[i].idx, PLAN[i].data);
      end else begin
        send_tick(PLAN[i].restart, PLAN[i].typed, PLAN[i].want);
      end
    end

    // random phases: new settings, then mostly whole bursts with idle ticks
    // between them, a few cut short and a few stray restarts
    left = 1;
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_quiet();

      if ($urandom_range(0, 5) != 0) begin
        case ($urandom_range(0, 4))
          0:       val = '0;
          1:       val = 48'h7FFF_FFFF_FFFF;
          default: val = 48'({$urandom(), $urandom()});  // top bit is dropped
        endcase
        write_reg(CFG_START_INCREMENT, val);
      end

      if ($urandom_range(0, 5) != 0) begin
        case ($urandom_range(0, 5))
          0: val = '0;
          1: val = 48'h7FFF_FFFF_FFFF;
          2: val = 48'h8000_0000_0000;
          3: val = 48'({$urandom(), $urandom()});
          default: begin
            val = 48'($urandom_range(0, 1 << 22));
            if ($urandom_range(0, 1) == 1) begin
              val = -val;
            end
          end
        endcase
        write_reg(CFG_INCREMENT_SLOPE, val);
      end

      // mostly short bursts so that they end inside the phase
      case ($urandom_range(0, 9))
        0:       cnt = '0;
        1:       cnt = '1;
        2, 3:    cnt = CNT_W'($urandom_range(41, 400));
        default: cnt = CNT_W'($urandom_range(1, 40));
      endcase
      span = (cnt == 0) ? 1 : cnt;
      write_reg(CFG_SAMPLE_COUNT, CFG_DATA_W'(cnt));

      if ($urandom_range(0, 5) != 0) begin
        case ($urandom_range(0, 7))
          0:       val = '0;
          1:       val = CFG_DATA_W'(ENV_FULL);
          2:       val = 48'h1FF_FFFF;
          3:       val = CFG_DATA_W'($urandom_range(0, 32'h1FF_FFFF));
          default: val = CFG_DATA_W'($urandom_range(0, 2 * (ENV_FULL / span)));
        endcase
        write_reg(CFG_ENVELOPE_STEP, val);
      end

      if ($urandom_range(0, 5) != 0) begin
        case ($urandom_range(0, 6))
          0:       val = '0;
          1:       val = 48'd32768;
          2:       val = 48'hFFFF;
          3:       val = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
          default: val = CFG_DATA_W'($urandom_range(0, 32768));
        endcase
        write_reg(CFG_VOLUME, val);
      end

      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                  48'({$urandom(), $urandom()}));
      end

      // usually restart on the new settings, otherwise carry the burst over
      if ($urandom_range(0, 3) != 0) begin
        left = 0;
      end

      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (left <= 0) begin
          rs   = 1'b1;
          left = span + $urandom_range(0, 3);
          if ($urandom_range(0, 7) == 0) begin
            left = $urandom_range(1, span);
          end
        end else begin
          rs = ($urandom_range(0, 63) == 0);
        end
        left--;
        send_tick(rs, 1'b0, ZERO_RUN);
      end
    end

    wait_quiet();
    if (expected_samples.size() != 0) begin
      $error("%0d sample items never arrived", expected_samples.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_linear_chirp_burst_generator_top: PASS");
    end else begin
      $display("tb_linear_chirp_burst_generator_top: FAIL");
    end
    $finish;
  end

endmodule
